>>> sv/assert_macros.svh
// Assertion helper macros shared by the destination filter RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PIDF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidf: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PIDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidf: next-cycle check failed");

`endif

>>> sv/pidf_pkg.sv
// Package for the public destination filter: family codes, address constants
// and the structs passed between pipeline stages. No dependencies.
package pidf_pkg;

    // Address family codes
    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    // IPv4 special-purpose prefix table
    localparam int V4_RANGES = 15;

    localparam logic [31:0] V4_BASE [V4_RANGES] = '{
        32'h00000000, 32'h0a000000, 32'h64400000, 32'h7f000000,
        32'ha9fe0000, 32'hac100000, 32'hc0000000, 32'hc0000200,
        32'hc0586300, 32'hc0a80000, 32'hc6120000, 32'hc6336400,
        32'hcb007100, 32'he0000000, 32'hf0000000
    };

    localparam logic [31:0] V4_MASK [V4_RANGES] = '{
        32'hff000000, 32'hff000000, 32'hffc00000, 32'hff000000,
        32'hffff0000, 32'hfff00000, 32'hffffff00, 32'hffffff00,
        32'hffffff00, 32'hffff0000, 32'hfffe0000, 32'hffffff00,
        32'hffffff00, 32'hf0000000, 32'hf0000000
    };

    // IPv6 embedded-IPv4 prefixes (::ffff:0:0/96 and 64:ff9b::/96)
    localparam logic [63:0] V6_MAPPED_HI   = 64'h0000000000000000;
    localparam logic [31:0] V6_MAPPED_LO   = 32'h0000ffff;
    localparam logic [63:0] V6_NAT64_HI    = 64'h0064ff9b00000000;
    localparam logic [31:0] V6_NAT64_LO    = 32'h00000000;

    // IPv6 global unicast 2000::/3 and its excluded blocks
    localparam logic [7:0]  V6_GLOBAL_MASK = 8'he0;
    localparam logic [7:0]  V6_GLOBAL_BASE = 8'h20;
    localparam logic [7:0]  V6_TEREDO_B1   = 8'h01;
    localparam logic [7:0]  V6_TEREDO_B2   = 8'h02;
    localparam logic [7:0]  V6_6TO4_B1     = 8'h02;

    // Stage 1 result: which path decides, and the IPv4 word to check
    typedef struct packed {
        logic        v4_sel;
        logic        v6_pub;
        logic [31:0] v4_addr;
    } dec_t;

    // Stage 2 result: prefix hits in place of the address
    typedef struct packed {
        logic                 v4_sel;
        logic                 v6_pub;
        logic [V4_RANGES-1:0] hit;
    } match_t;

endpackage

>>> sv/pidf_decode.sv
// Stage 1 of the destination filter: family decode and IPv6 prefix checks.
// Depends on pidf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pidf_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        family,
    input  logic              length_ok,
    input  logic [63:0]       addr_hi,
    input  logic [63:0]       addr_lo,
    output logic              out_valid,
    input  logic              out_ready,
    output pidf_pkg::dec_t    out_data
);

    logic           valid_reg;
    pidf_pkg::dec_t data_reg;
    pidf_pkg::dec_t data_next;
    logic           mapped;
    logic           nat64;
    logic           v6_global;
    logic           v6_excluded;

    // Match the embedded-IPv4 prefixes and the global unicast rule
    always_comb
    begin
        mapped      = (addr_hi == pidf_pkg::V6_MAPPED_HI) &&
                      (addr_lo[63:32] == pidf_pkg::V6_MAPPED_LO);
        nat64       = (addr_hi == pidf_pkg::V6_NAT64_HI) &&
                      (addr_lo[63:32] == pidf_pkg::V6_NAT64_LO);
        v6_global   = (addr_hi[63:56] & pidf_pkg::V6_GLOBAL_MASK) ==
                      pidf_pkg::V6_GLOBAL_BASE;
        v6_excluded = (addr_hi[63:56] == pidf_pkg::V6_GLOBAL_BASE) &&
                      (((addr_hi[55:48] == pidf_pkg::V6_TEREDO_B1) &&
                        (addr_hi[47:40] < pidf_pkg::V6_TEREDO_B2)) ||
                       (addr_hi[55:48] == pidf_pkg::V6_6TO4_B1));
    end

    // Pick the deciding path per family
    always_comb
    begin
        data_next.v4_sel  = 1'b0;
        data_next.v6_pub  = 1'b0;
        data_next.v4_addr = addr_lo[31:0];
        if (length_ok)
        begin
            case (family)
                pidf_pkg::FAM_V4:
                begin
                    data_next.v4_sel = 1'b1;
                end
                pidf_pkg::FAM_V6:
                begin
                    data_next.v4_sel = mapped || nat64;
                    data_next.v6_pub = !(mapped || nat64) && v6_global && !v6_excluded;
                end
                default:
                begin
                    data_next.v4_sel = 1'b0;
                end
            endcase
        end
    end

    // Advance when the slot is empty or the next stage takes it
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `PIDF_ASSERT_NEXT(a_dec_hold, valid_reg && !out_ready, valid_reg && $stable(data_reg))
    `PIDF_ASSERT_SAME(a_dec_one_path, valid_reg, !(data_reg.v4_sel && data_reg.v6_pub))

endmodule

>>> sv/pidf_v4_match.sv
// Stage 2 of the destination filter: compare the IPv4 word against all
// special-purpose prefixes in parallel. Depends on pidf_pkg.
module pidf_v4_match (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pidf_pkg::dec_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pidf_pkg::match_t   out_data
);

    logic                          valid_reg;
    pidf_pkg::match_t              data_reg;
    pidf_pkg::match_t              data_next;
    logic [pidf_pkg::V4_RANGES-1:0] hit;

    // Test each prefix on its own
    for (genvar i = 0; i < pidf_pkg::V4_RANGES; i++)
    begin : g_prefix
        assign hit[i] = (in_data.v4_addr & pidf_pkg::V4_MASK[i]) == pidf_pkg::V4_BASE[i];
    end

    always_comb
    begin
        data_next.v4_sel = in_data.v4_sel;
        data_next.v6_pub = in_data.v6_pub;
        data_next.hit    = hit;
    end

    // Advance when the slot is empty or the next stage takes it
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/public_ip_destination_filter.sv
// Public destination filter: one address transaction in, one is_public
// result out. A transaction passes three register stages (decode, prefix
// compare, resolve): it is captured at the accepting edge, then its result is
// offered on out_valid. A new one is taken every cycle unless stalled; the
// ready chain runs combinationally from out_ready back to in_ready, so the
// input stalls only when all three stages are full and the output is held.
// Depends on pidf_pkg, pidf_decode, pidf_v4_match and assert_macros.svh.
`include "assert_macros.svh"

module public_ip_destination_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  family,
    input  logic        length_ok,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_public
);

    logic             dec_valid;
    logic             dec_ready;
    pidf_pkg::dec_t   dec_data;
    logic             mat_valid;
    logic             mat_ready;
    pidf_pkg::match_t mat_data;
    logic             valid_reg;
    logic             pub_reg;
    logic             pub_next;

    pidf_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .family    (family),
        .length_ok (length_ok),
        .addr_hi   (addr_hi),
        .addr_lo   (addr_lo),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    pidf_v4_match u_v4_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_data  (mat_data)
    );

    // Resolve: an IPv4 decision is public only when no prefix hit
    assign pub_next  = mat_data.v4_sel ? !(|mat_data.hit) : mat_data.v6_pub;
    assign mat_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (mat_ready)
        begin
            valid_reg <= mat_valid;
        end
    end

    // Hold the result until the transaction is taken
    always_ff @(posedge clk)
    begin
        if (mat_valid && mat_ready)
        begin
            pub_reg <= pub_next;
        end
    end

    assign out_valid = valid_reg;
    assign is_public = pub_reg;

    `PIDF_ASSERT_SAME(a_full_when_blocked, !in_ready, dec_valid && mat_valid && valid_reg)
    `PIDF_ASSERT_SAME(a_out_from_match, $rose(valid_reg), $past(mat_valid))
    `PIDF_ASSERT_NEXT(a_match_hold, mat_valid && !mat_ready, mat_valid && $stable(mat_data))

endmodule

>>> tb/public_ip_destination_filter_test.sv
// Self-checking testbench for public_ip_destination_filter: a queued driver,
// a randomly stalling receiver and a scoreboard against an inline predictor.
// Depends on pidf_pkg and the public_ip_destination_filter RTL.
module public_ip_destination_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Family codes beyond the two the package names
    localparam logic [1:0] FAM_OTHER = 2'd2;
    localparam logic [1:0] FAM_SPARE = 2'd3;

    // Embedded-IPv4 prefixes as the predictor sees them
    localparam logic [31:0] MAPPED_TOP = 32'h0000ffff;
    localparam logic [63:0] NAT64_HI   = 64'h0064ff9b00000000;

    localparam int RANDOM_ADDRS = 900;
    localparam int PRESSURE_AT  = 300;
    localparam int PRESSURE_LEN = 150;

    typedef struct {
        logic [1:0]  fam;
        logic        len_ok;
        logic [63:0] hi;
        logic [63:0] lo;
    } addr_txn_t;

    typedef struct {
        addr_txn_t txn;
        logic      pub;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  family;
    logic        length_ok;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        out_valid;
    logic        out_ready;
    logic        is_public;

    addr_txn_t addr_queue [$];
    verdict_t  verdict_queue [$];
    addr_txn_t next_addr;
    verdict_t  oldest;

    int  fail_count = 0;
    int  addrs_taken = 0;
    int  tx_gap = 0;
    int  rx_hold = 0;
    bit  pressure_done = 0;
    bit  in_fire = 0;
    bit  burst = 0;

    public_ip_destination_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .family    (family),
        .length_ok (length_ok),
        .addr_hi   (addr_hi),
        .addr_lo   (addr_lo),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_public (is_public)
    );

    // Clock: 2 ns period
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // IPv4 special-purpose prefixes, returned as {base, mask}
    function automatic logic [63:0] v4_special(int idx);
        case (idx)
            0:       return {32'h00000000, 32'hff000000};
            1:       return {32'h0a000000, 32'hff000000};
            2:       return {32'h64400000, 32'hffc00000};
            3:       return {32'h7f000000, 32'hff000000};
            4:       return {32'ha9fe0000, 32'hffff0000};
            5:       return {32'hac100000, 32'hfff00000};
            6:       return {32'hc0000000, 32'hffffff00};
            7:       return {32'hc0000200, 32'hffffff00};
            8:       return {32'hc0586300, 32'hffffff00};
            9:       return {32'hc0a80000, 32'hffff0000};
            10:      return {32'hc6120000, 32'hfffe0000};
            11:      return {32'hc6336400, 32'hffffff00};
            12:      return {32'hcb007100, 32'hffffff00};
            13:      return {32'he0000000, 32'hf0000000};
            default: return {32'hf0000000, 32'hf0000000};
        endcase
    endfunction

    function automatic logic v4_routable(logic [31:0] a);
        logic [63:0] pm;
        for (int i = 0; i < 15; i++)
        begin
            pm = v4_special(i);
            if ((a & pm[31:0]) == pm[63:32])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Predict is_public for one address transaction
    function automatic logic public_verdict(addr_txn_t t);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       embedded;
        b0 = t.hi[63:56];
        b1 = t.hi[55:48];
        b2 = t.hi[47:40];
        embedded = (t.hi == 64'd0 && t.lo[63:32] == MAPPED_TOP)
                || (t.hi == NAT64_HI && t.lo[63:32] == 32'd0);
        if (!t.len_ok)
            return 1'b0;
        if (t.fam == pidf_pkg::FAM_V4)
            return v4_routable(t.lo[31:0]);
        if (t.fam != pidf_pkg::FAM_V6)
            return 1'b0;
        if (embedded)
            return v4_routable(t.lo[31:0]);
        if ((b0 & 8'he0) != 8'h20)
            return 1'b0;
        if (b0 == 8'h20 && ((b1 == 8'h01 && b2 < 8'h02) || b1 == 8'h02))
            return 1'b0;
        return 1'b1;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // IPv4 word: random, inside a special prefix, or just outside one
    function automatic logic [31:0] rand_v4();
        logic [63:0] pm;
        logic [31:0] a;
        int          ones;
        int          bitpos;
        pm = v4_special($urandom_range(0, 14));
        a = $urandom;
        if ($urandom_range(0, 2) == 0)
            return a;
        a = pm[63:32] | (a & ~pm[31:0]);
        if ($urandom_range(0, 1) == 0)
            return a;
        ones = $countones(pm[31:0]);
        bitpos = 32 - $urandom_range(1, ones);
        a[bitpos] = ~a[bitpos];
        return a;
    endfunction

    // IPv6 address as {hi, lo}, biased toward the interesting prefixes
    function automatic logic [127:0] rand_v6();
        logic [63:0] hi;
        logic [63:0] lo;
        int          k;
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:
            begin
                hi = 64'd0;
                lo = {MAPPED_TOP, rand_v4()};
            end
            1:
            begin
                hi = NAT64_HI;
                lo = {32'd0, rand_v4()};
            end
            2:
                hi[63:61] = 3'b001;
            3:
            begin
                hi[63:56] = 8'h20;
                k = $urandom_range(0, 3);
                hi[55:48] = 8'(k);
                if ($urandom_range(0, 1) == 0)
                    hi[47:40] = 8'($urandom_range(0, 3));
            end
            4:
            begin
                // one bit away from an embedded-IPv4 prefix
                hi = ($urandom_range(0, 1) == 0) ? 64'd0 : NAT64_HI;
                lo = {(hi == 64'd0) ? MAPPED_TOP : 32'd0, rand_v4()};
                k = $urandom_range(0, 95);
                if (k < 64)
                    hi[k] = ~hi[k];
                else
                    lo[k - 32] = ~lo[k - 32];
            end
            default:
            begin
            end
        endcase
        return {hi, lo};
    endfunction

    function automatic addr_txn_t rand_addr();
        addr_txn_t t;
        int        r;
        logic [127:0] v6;
        r = $urandom_range(0, 99);
        t.len_ok = ($urandom_range(0, 19) != 0);
        t.hi = {$urandom, $urandom};
        t.lo = {$urandom, rand_v4()};
        if (r < 46)
            t.fam = pidf_pkg::FAM_V4;
        else if (r < 92)
        begin
            t.fam = pidf_pkg::FAM_V6;
            v6 = rand_v6();
            t.hi = v6[127:64];
            t.lo = v6[63:0];
        end
        else
            t.fam = (r < 96) ? FAM_OTHER : FAM_SPARE;
        return t;
    endfunction

    task automatic push_addr(logic [1:0] fam, logic len_ok, logic [63:0] hi,
                             logic [63:0] lo);
        addr_txn_t t;
        t.fam = fam;
        t.len_ok = len_ok;
        t.hi = hi;
        t.lo = lo;
        addr_queue = {addr_queue, t};
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        family = pidf_pkg::FAM_V4;
        length_ok = 1'b0;
        addr_hi = 64'd0;
        addr_lo = 64'd0;

        // Directed: prefix edges, embedded IPv4, IPv6 exclusions, odd records
        push_addr(pidf_pkg::FAM_V4, 1'b1, 64'd0, 64'h00000000_00000000);
        push_addr(pidf_pkg::FAM_V4, 1'b1, '1, '1);
        push_addr(pidf_pkg::FAM_V4, 1'b1, '1, 64'hffffffff_08080808);
        push_addr(pidf_pkg::FAM_V4, 1'b0, 64'd0, 64'h00000000_08080808);
        push_addr(pidf_pkg::FAM_V4, 1'b1, 64'd0, 64'h00000000_64400000);
        push_addr(pidf_pkg::FAM_V4, 1'b1, 64'd0, 64'h00000000_64800000);
        push_addr(pidf_pkg::FAM_V4, 1'b1, 64'd0, 64'h00000000_ac1fffff);
        push_addr(pidf_pkg::FAM_V4, 1'b1, 64'd0, 64'h00000000_ac200000);
        push_addr(pidf_pkg::FAM_V4, 1'b1, 64'd0, 64'h00000000_c613ffff);
        push_addr(pidf_pkg::FAM_V4, 1'b1, 64'd0, 64'h00000000_c6140000);
        push_addr(pidf_pkg::FAM_V4, 1'b1, 64'd0, 64'h00000000_dfffffff);
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'd0, {MAPPED_TOP, 32'h08080808});
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'd0, {MAPPED_TOP, 32'h0a000001});
        push_addr(pidf_pkg::FAM_V6, 1'b1, NAT64_HI, {32'd0, 32'h01010101});
        push_addr(pidf_pkg::FAM_V6, 1'b1, NAT64_HI, {32'd0, 32'hc0a80101});
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'h20014860_00000000, 64'd1);
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'h20010100_00000000, 64'd1);
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'h20010200_00000000, 64'd1);
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'h2002ffff_ffffffff, '1);
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'h3fffffff_ffffffff, '1);
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'h40000000_00000000, 64'd0);
        push_addr(pidf_pkg::FAM_V6, 1'b1, 64'd0, 64'd0);
        push_addr(pidf_pkg::FAM_V6, 1'b0, 64'h20014860_00000000, 64'd1);
        push_addr(FAM_OTHER, 1'b1, 64'd0, 64'h00000000_08080808);
        push_addr(FAM_SPARE, 1'b1, 64'h20014860_00000000, 64'd1);

        for (int i = 0; i < RANDOM_ADDRS; i++)
            addr_queue = {addr_queue, rand_addr()};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: all sent, all verdicts seen, then let the pipeline settle
        @(posedge clk);
        while (addr_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    // Driver: hold a transaction until taken, then advance after a gap
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
        begin
            // hold
        end
        else if (tx_gap > 0)
        begin
            tx_gap <= tx_gap - 1;
            in_valid <= 1'b0;
        end
        else if (addr_queue.size() != 0)
        begin
            next_addr = addr_queue.pop_front();
            family <= next_addr.fam;
            length_ok <= next_addr.len_ok;
            addr_hi <= next_addr.hi;
            addr_lo <= next_addr.lo;
            in_valid <= 1'b1;
            tx_gap <= burst ? 0 : gap_len();
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: random stalls, one long hold-off to back up the pipeline
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!pressure_done && addrs_taken >= PRESSURE_AT)
        begin
            pressure_done <= 1'b1;
            rx_hold <= PRESSURE_LEN;
            out_ready <= 1'b0;
        end
        else if (burst || $urandom_range(0, 99) < 70)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            rx_hold <= gap_len();
        end
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
        begin
            oldest.txn.fam = family;
            oldest.txn.len_ok = length_ok;
            oldest.txn.hi = addr_hi;
            oldest.txn.lo = addr_lo;
            oldest.pub = public_verdict(oldest.txn);
            verdict_queue = {verdict_queue, oldest};
            addrs_taken = addrs_taken + 1;
            if ($urandom_range(0, 63) == 0)
                burst = !burst;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got is_public %0b",
                         $realtime, is_public);
                fail_count = fail_count + 1;
            end
            else
            begin
                oldest = verdict_queue.pop_front();
                if (is_public !== oldest.pub)
                begin
                    $display("%0t: expected %0b got %0b (fam %0d len %0b addr %h_%h)",
                             $realtime, oldest.pub, is_public, oldest.txn.fam,
                             oldest.txn.len_ok, oldest.txn.hi, oldest.txn.lo);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

endmodule
